// File: rtl/core/rdiv_pkg.sv
package rdiv_pkg;

  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIVISOR_W  = 16;
  localparam int unsigned QUOTIENT_W = 32;

  // one restoring step per cell
  localparam int unsigned NUM_STEPS = DIVIDEND_W;

  // acc holds the dividend bits still to be consumed in its upper part
  // and the quotient bits produced so far in its lower part
  typedef struct packed {
    logic                  valid;
    logic [DIVIDEND_W-1:0] acc;
    logic [DIVISOR_W-1:0]  rem;
    logic [DIVISOR_W-1:0]  den;
  } rdiv_stage_t;

endpackage

// File: rtl/core/rounding_unsigned_divider.sv
// Unsigned 32 by 16 bit divider with the quotient rounded half up (modulo 2^32;
// a zero divisor gives zero). A beat is taken on any cycle with start high;
// busy never rises, so one beat per clock is sustained. The answer appears on
// quotient with done high for exactly one cycle, once the beat has passed 32
// cells of restoring shift-subtract, one per quotient bit, then one
// rounding stage. Results come out in order and cannot be held off, so the
// receiver must take each one on its done cycle.
module rounding_unsigned_divider
  import rdiv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [QUOTIENT_W-1:0] quotient
);

  rdiv_stage_t stage [0:NUM_STEPS];

  // fully pipelined, never stalls
  assign busy = 1'b0;

  assign stage[0] = {start & ~busy, dividend, {DIVISOR_W{1'b0}}, divisor};

  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_cell
    rdiv_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .prev (stage[i]),
      .curr (stage[i+1])
    );
  end

  rdiv_round u_round (
    .clk      (clk),
    .rst      (rst),
    .prev     (stage[NUM_STEPS]),
    .done     (done),
    .quotient (quotient)
  );

endmodule

// File: rtl/core/rdiv_cell.sv
module rdiv_cell
  import rdiv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  rdiv_stage_t prev,
  output rdiv_stage_t curr
);

  logic [DIVISOR_W:0] shifted;
  logic [DIVISOR_W:0] diff;
  logic               fits;
  rdiv_stage_t        curr_next;

  always_comb begin
    shifted = {prev.rem, prev.acc[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, prev.den};
    fits    = shifted >= {1'b0, prev.den};
    curr_next.valid = prev.valid;
    curr_next.acc   = {prev.acc[DIVIDEND_W-2:0], fits};
    // remainder stays below the divisor, so it fits back into divisor width
    curr_next.rem   = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    curr_next.den   = prev.den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      curr.valid <= 1'b0;
    end else begin
      curr.valid <= curr_next.valid;
    end
    curr.acc <= curr_next.acc;
    curr.rem <= curr_next.rem;
    curr.den <= curr_next.den;
  end

endmodule

// File: rtl/core/rdiv_round.sv
module rdiv_round
  import rdiv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  rdiv_stage_t           prev,
  output logic                  done,
  output logic [QUOTIENT_W-1:0] quotient
);

  logic                  round_up;
  logic [QUOTIENT_W-1:0] quotient_next;

  always_comb begin
    // half up: twice the remainder against the divisor, zero divisor always wraps
    round_up      = {prev.rem, 1'b0} >= {1'b0, prev.den};
    quotient_next = prev.acc + {{(QUOTIENT_W-1){1'b0}}, round_up};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prev.valid;
    end
    quotient <= quotient_next;
  end

endmodule

// File: rtl/core/rdiv_checker.sv
module rdiv_props
  import rdiv_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic [DIVIDEND_W-1:0] dividend,
  input logic [DIVISOR_W-1:0]  divisor,
  input logic                  done,
  input logic [QUOTIENT_W-1:0] quotient
);

  localparam int unsigned LATENCY = NUM_STEPS + 1;

  // every beat taken gives a result after the fixed latency
  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted beat produced no result");

  // no result without a beat taken earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start, LATENCY) && !$past(busy, LATENCY)))
    else $error("result without matching beat");

  // zero divisor wraps to zero
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && divisor == '0) |-> ##LATENCY (quotient == '0))
    else $error("zero divisor did not give zero");

  // divide by one passes the dividend through
  a_unit_div: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && divisor == {{(DIVISOR_W-1){1'b0}}, 1'b1})
      |-> ##LATENCY (quotient == $past(dividend, LATENCY)))
    else $error("divide by one changed the dividend");

endmodule

bind rounding_unsigned_divider rdiv_props u_rdiv_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .dividend (dividend),
  .divisor  (divisor),
  .done     (done),
  .quotient (quotient)
);

// File: tb/sv/rdiv_checker.sv
module rdiv_checker
  import rdiv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  input  logic                  done,
  input  logic [QUOTIENT_W-1:0] quotient,
  output int unsigned           mismatches,
  output int unsigned           checked,
  output int unsigned           pending,
  output int unsigned           zero_divides,
  output int unsigned           round_ups
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    logic [DIVIDEND_W-1:0] num;
    logic [DIVISOR_W-1:0]  den;
    logic [QUOTIENT_W-1:0] quo;
  } division_t;

  division_t quotients_due[$];

  // quotient rounded half up, wrapped to the field width
  function automatic logic [QUOTIENT_W-1:0] rounded_quotient(
    input logic [DIVIDEND_W-1:0] num,
    input logic [DIVISOR_W-1:0]  den
  );
    logic [DIVIDEND_W:0]  q;
    logic [DIVISOR_W-1:0] r;
    // a zero divisor gives an all-ones raw quotient that always rounds up and wraps
    if (den == '0) return '0;
    q = {1'b0, num / den};
    r = DIVISOR_W'(num % den);
    if ({r, 1'b0} >= {1'b0, den}) q = q + (DIVIDEND_W+1)'(1);
    return q[QUOTIENT_W-1:0];
  endfunction

  always @(posedge clk) begin
    division_t beat;
    division_t due;
    if (!rst) begin
      if (start && !busy) begin
        beat.num = dividend;
        beat.den = divisor;
        beat.quo = rounded_quotient(dividend, divisor);
        if (divisor == '0) begin
          zero_divides++;
        end else if (beat.quo != QUOTIENT_W'(dividend / divisor)) begin
          round_ups++;
        end
        quotients_due.push_back(beat);
      end
      if (done) begin
        if (quotients_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected quotient %h with nothing outstanding", quotient);
        end else begin
          due = quotients_due.pop_front();
          checked++;
          if (quotient !== due.quo) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("quotient mismatch: %h / %h expected %h got %h",
                       due.num, due.den, due.quo, quotient);
          end
        end
      end
      pending = quotients_due.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  import rdiv_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1800;
  localparam int unsigned PIPE_DEPTH   = 33;
  localparam int unsigned IDLE_LIMIT   = 400;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVISOR_W-1:0]  divisor;
  logic                  done;
  logic [QUOTIENT_W-1:0] quotient;

  int unsigned mismatches;
  int unsigned checked;
  int unsigned pending;
  int unsigned zero_divides;
  int unsigned round_ups;
  int unsigned idle_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rounding_unsigned_divider DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (done),
    .quotient (quotient)
  );

  rdiv_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .dividend     (dividend),
    .divisor      (divisor),
    .done         (done),
    .quotient     (quotient),
    .mismatches   (mismatches),
    .checked      (checked),
    .pending      (pending),
    .zero_divides (zero_divides),
    .round_ups    (round_ups)
  );

  // watchdog: cycles with neither an operand beat nor a quotient
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("rounding_unsigned_divider test failed");
        $finish;
      end
    end
  end

  task automatic send_division(input logic [DIVIDEND_W-1:0] num,
                               input logic [DIVISOR_W-1:0] den);
    @(negedge clk);
    start    <= 1'b1;
    dividend <= num;
    divisor  <= den;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic pick_operands(output logic [DIVIDEND_W-1:0] num,
                               output logic [DIVISOR_W-1:0] den);
    logic [DIVIDEND_W+DIVISOR_W-1:0] wide;
    int unsigned half;
    int unsigned r;
    num = $urandom;
    den = DIVISOR_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      0: den = '0;
      1: den = DIVISOR_W'(1);
      2: den = DIVISOR_W'(1) << $urandom_range(0, DIVISOR_W - 1);
      3: den = DIVISOR_W'($urandom_range(1, 15));
      4: begin
        // remainder at or next to half the divisor
        if (den < 2) den = DIVISOR_W'(2);
        half = den / 2;
        r = half + $urandom_range(0, 2) - 1;
        if (r >= den) r = den - 1;
        // quotient kept small enough that the product stays in range
        wide = (DIVIDEND_W+DIVISOR_W)'($urandom_range(0, 32'hffff_ffff / den - 1)) * den + r;
        num  = wide[DIVIDEND_W-1:0];
      end
      5: num = (den == '0) ? $urandom_range(0, 3) : $urandom_range(0, den - 1);
      6: begin
        case ($urandom_range(0, 3))
          0: num = '0;
          1: num = '1;
          2: num = 32'h8000_0000;
          default: num = 32'h7fff_ffff;
        endcase
      end
      7: den = DIVISOR_W'(32'h0000_ffff - $urandom_range(0, 3));
      default: ;
    endcase
  endtask

  initial begin
    logic [DIVIDEND_W-1:0] num;
    logic [DIVISOR_W-1:0]  den;
    int unsigned burst;
    int unsigned sent;

    rst      = 1'b1;
    start    = 1'b0;
    dividend = '0;
    divisor  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero divisor, full-scale operands, exact and near ties
    send_division(32'h0000_0000, 16'h0000);
    send_division(32'hffff_ffff, 16'h0000);
    send_division(32'h1234_5678, 16'h0000);
    send_division(32'h0000_0000, 16'h0001);
    send_division(32'hffff_ffff, 16'h0001);
    send_division(32'hffff_ffff, 16'hffff);
    send_division(32'h0000_0000, 16'hffff);
    send_division(32'h8000_0000, 16'hffff);
    send_division(32'hffff_ffff, 16'h0002);
    send_division(32'hffff_fffe, 16'h0002);
    send_division(32'h0000_0005, 16'h0002);
    send_division(32'h0000_0001, 16'h0002);
    send_division(32'h0000_0001, 16'h0003);
    send_division(32'h0000_0007, 16'h0003);
    send_division(32'h0000_0008, 16'h0003);
    send_division(32'h0000_7fff, 16'hffff);
    send_division(32'h0000_8000, 16'hffff);
    hold_off(3);
    send_division(32'h7fff_ffff, 16'h8000);
    send_division(32'h0000_fffe, 16'hffff);
    send_division(32'haaaa_aaaa, 16'h5555);
    send_division(32'h5555_5555, 16'haaaa);
    send_division(32'hffff_ffff, 16'h8000);
    hold_off(PIPE_DEPTH + 5);

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      repeat (burst) begin
        pick_operands(num, den);
        send_division(num, den);
        sent++;
      end
      if ($urandom_range(0, 4) != 0) hold_off($urandom_range(1, 12));
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    $display("checked %0d quotients: %0d with zero divisor, %0d rounded up",
             checked, zero_divides, round_ups);
    if (mismatches == 0 && pending == 0) begin
      $display("rounding_unsigned_divider test passed");
    end else begin
      $display("%0d mismatches, %0d quotients never arrived", mismatches, pending);
      $display("rounding_unsigned_divider test failed");
    end
    $finish;
  end

endmodule

// File: rounding_unsigned_divider.f
rtl/core/rdiv_pkg.sv
rtl/core/rdiv_cell.sv
rtl/core/rdiv_round.sv
rtl/core/rounding_unsigned_divider.sv
rtl/core/rdiv_checker.sv
tb/sv/rdiv_checker.sv
tb/sv/tb_top.sv
